@@ rtl/core/cst_pkg.sv @@
// shared types and constants of the csv stream tokenizer
package cst_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] SeparatorReset = 8'd44;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_FIELD = 2'd1,
    EV_ROW   = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  out_byte;
    logic        last_of_run;
  } out_beat_t;

  // one classified input byte: one or two events to play out
  typedef struct packed {
    logic [1:0]  n_ev;
    event_kind_e kind0;
    event_kind_e kind1;
    logic [7:0]  data;
  } cmd_t;

endpackage

@@ rtl/core/csv_stream_tokenizer.sv @@
// top level of the csv stream tokenizer
// One byte (or end-of-stream marker) is taken per cycle while full is low; the front end
// classifies it at once and files zero, one or two events into a four-entry command queue.
// The back end hands out one event per cycle while pop is high, so a byte that yields a
// doubled quote or a field end with a row end gives two result beats; full rises only
// when the command queue fills. The separator is written through the cfg channel, which
// is always ready, and resets to a comma.
module csv_stream_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cst_pkg::in_beat_t  in_beat_i,
  output logic               empty,
  input  logic               pop,
  output cst_pkg::out_beat_t out_beat_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import cst_pkg::*;

  logic [7:0] sep_q;
  logic       accept;
  logic       cmd_valid;
  cmd_t       cmd;
  cmd_t       q_data;
  logic       q_rd;
  logic       q_empty;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SeparatorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sep_q <= cfg_data_i;
    end
  end

  cst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .beat_i      (in_beat_i),
    .separator_i (sep_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  cst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_valid),
    .wdata_i (cmd),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .full_o  (full),
    .empty_o (q_empty)
  );

  cst_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .beat_o    (out_beat_o)
  );

  // non-data events carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_beat_o.event_kind != EV_DATA |-> out_beat_o.out_byte == 8'd0)
    else $error("non-data beat with nonzero byte");

  // the second event of a command follows right after the first
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !out_beat_o.last_of_run |=> !empty)
    else $error("second event of a byte went missing");

  // a row end is always the final event of its byte
  a_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_beat_o.event_kind == EV_ROW |-> out_beat_o.last_of_run)
    else $error("row end not last of run");

endmodule

@@ rtl/core/cst_front.sv @@
// front end: classifies each input byte and keeps the quote and field flags
module cst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cst_pkg::in_beat_t beat_i,
  input  logic [7:0]        separator_i,
  output logic              cmd_valid_o,
  output cst_pkg::cmd_t     cmd_o
);
  import cst_pkg::*;

  logic iq_q, iq_d, qp_q, qp_d, fhd_q, fhd_d, rhf_q, rhf_d;

  always_comb begin
    logic       iq_eff;
    logic       plain;
    logic       close_f;
    logic       close_r;
    logic       is_data;
    logic       is_dq;
    logic [7:0] c;
    c       = beat_i.in_byte;
    iq_d    = iq_q;
    qp_d    = qp_q;
    fhd_d   = fhd_q;
    rhf_d   = rhf_q;
    iq_eff  = iq_q;
    plain   = 1'b0;
    close_f = 1'b0;
    close_r = 1'b0;
    is_data = 1'b0;
    is_dq   = 1'b0;

    if (beat_i.stream_end) begin
      qp_d    = 1'b0;
      iq_d    = 1'b0;
      close_f = fhd_q;
      close_r = rhf_q | fhd_q;
    end else if (qp_q) begin
      qp_d = 1'b0;
      if (c == ChQuote) begin
        is_dq = 1'b1;
      end else begin
        iq_eff = 1'b0;
        iq_d   = 1'b0;
        plain  = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain) begin
      if (!fhd_q && c == ChSpace) begin
        is_data = 1'b0;
      end else if (!fhd_q && !iq_eff && c == ChQuote) begin
        iq_d = 1'b1;
      end else if (iq_eff && c == ChQuote) begin
        qp_d = 1'b1;
      end else if (!iq_eff && c == separator_i) begin
        close_f = fhd_q;
      end else if (!iq_eff && (c == ChCr || c == ChLf)) begin
        close_f = fhd_q;
        close_r = rhf_q | fhd_q;
      end else begin
        is_data = 1'b1;
      end
    end

    if (is_data || is_dq) fhd_d = 1'b1;
    if (close_f) begin
      fhd_d = 1'b0;
      rhf_d = 1'b1;
    end
    if (close_r) rhf_d = 1'b0;

    cmd_o.data  = c;
    cmd_o.kind0 = EV_DATA;
    cmd_o.kind1 = EV_DATA;
    cmd_o.n_ev  = 2'd0;
    if (is_dq) begin
      cmd_o.data = ChQuote;
      cmd_o.n_ev = 2'd2;
    end else if (is_data) begin
      cmd_o.n_ev = 2'd1;
    end else if (close_f && close_r) begin
      cmd_o.kind0 = EV_FIELD;
      cmd_o.kind1 = EV_ROW;
      cmd_o.n_ev  = 2'd2;
    end else if (close_f) begin
      cmd_o.kind0 = EV_FIELD;
      cmd_o.n_ev  = 2'd1;
    end else if (close_r) begin
      cmd_o.kind0 = EV_ROW;
      cmd_o.n_ev  = 2'd1;
    end
    cmd_valid_o = accept_i && (cmd_o.n_ev != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q  <= 1'b0;
      qp_q  <= 1'b0;
      fhd_q <= 1'b0;
      rhf_q <= 1'b0;
    end else if (accept_i) begin
      iq_q  <= iq_d;
      qp_q  <= qp_d;
      fhd_q <= fhd_d;
      rhf_q <= rhf_d;
    end
  end

endmodule

@@ rtl/core/cst_queue.sv @@
// short command queue between front and back end
module cst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  cst_pkg::cmd_t wdata_i,
  input  logic          rd_i,
  output cst_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import cst_pkg::*;

  localparam logic [QueuePtrW:0] DepthC = (QueuePtrW + 1)'(QueueDepth);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/cst_back.sv @@
// back end: plays out the events of each command, one beat per cycle while pop is high
module cst_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  cst_pkg::cmd_t      q_data_i,
  output logic               q_rd_o,
  output logic               empty_o,
  input  logic               pop_i,
  output cst_pkg::out_beat_t beat_o
);
  import cst_pkg::*;

  cmd_t cur_q;
  logic cur_valid_q;
  logic idx_q;
  logic last;
  logic advance;

  assign empty_o = !cur_valid_q;
  assign last    = idx_q ? 1'b1 : (cur_q.n_ev == 2'd1);
  assign advance = !cur_valid_q || (pop_i && last);
  assign q_rd_o  = advance && !q_empty_i;

  always_comb begin
    beat_o.event_kind  = idx_q ? cur_q.kind1 : cur_q.kind0;
    beat_o.out_byte    = (beat_o.event_kind == EV_DATA) ? cur_q.data : 8'd0;
    beat_o.last_of_run = last;
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (advance) begin
      cur_valid_q <= !q_empty_i;
      idx_q       <= 1'b0;
    end else if (pop_i) begin
      idx_q <= 1'b1;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for the csv stream tokenizer: directed and random byte streams checked per event
`timescale 1ns / 100ps

module tb;
  import cst_pkg::*;

  localparam int unsigned ShowLimit  = 10;
  localparam int unsigned SettleCyc  = 4;
  localparam int unsigned HoldCyc    = 300;
  localparam int unsigned PhaseItems = 200;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_beat_t   in_beat_i;
  logic       empty;
  logic       pop;
  out_beat_t  out_beat_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  // predictor state
  logic [7:0]  sep_reg;
  bit          quoted;
  bit          quote_held;
  bit          field_open;
  bit          row_open;
  out_beat_t   token_q[$];
  out_beat_t   step_q[$];

  int unsigned mismatches;
  bit          src_idle;
  bit          snk_idle;
  int unsigned hold_off;

  csv_stream_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_beat_i   (in_beat_i),
    .empty       (empty),
    .pop         (pop),
    .out_beat_o  (out_beat_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** csv_stream_tokenizer: FAILED **");
    $finish;
  end

  task automatic put_event(input event_kind_e kind, input logic [7:0] ch);
    out_beat_t ev;
    ev.event_kind  = kind;
    ev.out_byte    = ch;
    ev.last_of_run = 1'b0;
    step_q.insert(step_q.size(), ev);
  endtask

  task automatic put_data(input logic [7:0] ch);
    put_event(EV_DATA, ch);
    field_open = 1'b1;
  endtask

  task automatic end_field();
    if (field_open) begin
      put_event(EV_FIELD, 8'h00);
      field_open = 1'b0;
      row_open   = 1'b1;
    end
  endtask

  task automatic end_row();
    if (row_open) begin
      put_event(EV_ROW, 8'h00);
      row_open = 1'b0;
    end
  endtask

  task automatic plain_char(input logic [7:0] ch);
    if (field_open || ch != ChSpace) begin
      if (!field_open && !quoted && ch == ChQuote) begin
        quoted = 1'b1;
      end else if (quoted && ch == ChQuote) begin
        quote_held = 1'b1;
      end else if (!quoted && ch == sep_reg) begin
        end_field();
      end else if (!quoted && (ch == ChCr || ch == ChLf)) begin
        end_field();
        end_row();
      end else begin
        put_data(ch);
      end
    end
  endtask

  task automatic predict_events(input in_beat_t b);
    out_beat_t ev;
    step_q.delete();
    if (b.stream_end) begin
      quote_held = 1'b0;
      quoted     = 1'b0;
      end_field();
      end_row();
    end else if (quote_held) begin
      quote_held = 1'b0;
      if (b.in_byte == ChQuote) begin
        put_data(ChQuote);
        put_data(ChQuote);
      end else begin
        quoted = 1'b0;
        plain_char(b.in_byte);
      end
    end else begin
      plain_char(b.in_byte);
    end
    foreach (step_q[i]) begin
      ev = step_q[i];
      ev.last_of_run = (i == step_q.size() - 1);
      token_q.insert(token_q.size(), ev);
    end
  endtask

  task automatic send_beat(input in_beat_t b);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (full);
    predict_events(b);
  endtask

  task automatic send_char(input logic [7:0] ch);
    in_beat_t b;
    b.in_byte    = ch;
    b.stream_end = 1'b0;
    send_beat(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_end();
    in_beat_t b;
    b.in_byte    = 8'($urandom_range(0, 255));
    b.stream_end = 1'b1;
    send_beat(b);
  endtask

  // mostly csv-shaped bytes, some noise and stream ends
  function automatic in_beat_t rand_beat();
    in_beat_t    b;
    int unsigned r;
    r = $urandom_range(0, 99);
    b.stream_end = 1'b0;
    if (r < 40) b.in_byte = 8'($urandom_range(8'h61, 8'h7A));
    else if (r < 50) b.in_byte = ChSpace;
    else if (r < 62) b.in_byte = ChQuote;
    else if (r < 74) b.in_byte = sep_reg;
    else if (r < 80) b.in_byte = ChCr;
    else if (r < 86) b.in_byte = ChLf;
    else begin
      b.in_byte    = 8'($urandom_range(0, 255));
      b.stream_end = (r < 90);
    end
    return b;
  endfunction

  task automatic wait_idle();
    push <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_separator(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sep_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_text(" a,");
    send_char(8'h00);
    send_char(8'hFF);
    send_text(",\r,\n");
    send_text("\"x\"\"y\" z\n");
    send_text("q\"");
    send_end();
    send_text("\"m\"");
    send_end();
    send_text("\"n,");
    send_end();
    send_end();
  endtask

  task automatic test_separators();
    logic [7:0] seps[8];
    seps = '{8'h00, 8'hFF, ChSpace, ChQuote, ChCr, ChLf, 8'h3B, 8'h09};
    foreach (seps[i]) begin
      wait_idle();
      write_separator(seps[i]);
      src_idle = (i % 2 == 0);
      snk_idle = (i % 4 < 2);
      repeat (40) send_beat(rand_beat());
      send_end();
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_separator(SeparatorReset);
    src_idle = 1'b0;
    hold_off = HoldCyc;
    repeat (60) send_beat(rand_beat());
    wait_idle();
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_separator(p == 0 ? SeparatorReset : 8'($urandom_range(0, 255)));
      src_idle = (p % 3 != 0);
      snk_idle = (p % 2 != 0);
      repeat (PhaseItems) send_beat(rand_beat());
    end
    send_end();
  endtask

  // result side: random stalls, one long hold-off on request, compare per beat
  initial begin
    int unsigned gap;
    out_beat_t   want;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off > 0) begin
        pop <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end
      gap = snk_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected beat: kind %0d byte %02h last %0b",
                   out_beat_o.event_kind, out_beat_o.out_byte, out_beat_o.last_of_run);
      end else begin
        want = token_q.pop_front();
        if (out_beat_o.event_kind !== want.event_kind || out_beat_o.out_byte !== want.out_byte ||
            out_beat_o.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display(
              "mismatch: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
              want.event_kind, want.out_byte, want.last_of_run,
              out_beat_o.event_kind, out_beat_o.out_byte, out_beat_o.last_of_run);
        end
      end
    end
  end

  initial begin
    sep_reg     = SeparatorReset;
    quoted      = 1'b0;
    quote_held  = 1'b0;
    field_open  = 1'b0;
    row_open    = 1'b0;
    mismatches  = 0;
    hold_off    = 0;
    src_idle    = 1'b0;
    snk_idle    = 1'b0;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_beat_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_separators();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("** csv_stream_tokenizer: PASSED **");
    end else begin
      $display("** csv_stream_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
